FILE: hdl/particle_physics_step_top_defines.svh
// ----------------------------------------------------------------------------
// particle_physics_step_top_defines.svh
// Assertion macros for the particle step pipeline control.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_PHYSICS_STEP_TOP_DEFINES_SVH
`define PARTICLE_PHYSICS_STEP_TOP_DEFINES_SVH

// expr must hold at every edge outside reset
`define PPS_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// ante implies cons in the same cycle
`define PPS_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types, constants and fixed-point helpers for the particle step pipeline.
// ----------------------------------------------------------------------------
package pps_pkg;

   // pipeline split
   localparam int unsigned FLIGHT_STAGES = 6;
   localparam int unsigned GROUND_STAGES = 4;
   localparam int unsigned PIPE_DEPTH    = FLIGHT_STAGES + GROUND_STAGES;

   // register map (word index)
   localparam logic [2:0] REG_GRAVITY_X      = 3'd0;
   localparam logic [2:0] REG_GRAVITY_Y      = 3'd1;
   localparam logic [2:0] REG_DAMPING        = 3'd2;
   localparam logic [2:0] REG_BOUNCE         = 3'd3;
   localparam logic [2:0] REG_SURFACE_GRIP   = 3'd4;
   localparam logic [2:0] REG_COLLIDE_ENABLE = 3'd5;
   localparam logic [2:0] REG_STICK_ENABLE   = 3'd6;
   localparam logic [2:0] REG_CONTACT_OFFSET = 3'd7;

   localparam int unsigned CSR_ADDR_W = 5;

   // reset values
   localparam logic signed [31:0] RST_GRAVITY_X      = 32'sd0;
   localparam logic signed [31:0] RST_GRAVITY_Y      = -32'sd13107200;
   localparam logic [15:0]        RST_DAMPING        = 16'd32113;
   localparam logic [15:0]        RST_BOUNCE         = 16'd9830;
   localparam logic [15:0]        RST_SURFACE_GRIP   = 16'd31130;
   localparam logic               RST_COLLIDE_ENABLE = 1'b1;
   localparam logic               RST_STICK_ENABLE   = 1'b0;
   localparam logic [30:0]        RST_CONTACT_OFFSET = 31'd65536;

   // ground plane at -200.0 in Q16.16, stick threshold 100.0 in Q32.32
   localparam logic signed [31:0] GROUND_Y    = -32'sd13107200;
   localparam logic [64:0]        STICK_LIMIT = 65'h64_0000_0000;
   localparam logic [23:0]        AGE_MAX     = 24'hFF_FFFF;

   localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
   localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

   typedef struct packed {
      logic signed [31:0] gravity_x;
      logic signed [31:0] gravity_y;
      logic [15:0]        damping;
      logic [15:0]        bounce;
      logic [15:0]        surface_grip;
      logic               collide_enable;
      logic               stick_enable;
      logic [30:0]        contact_offset;
   } pps_cfg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [23:0]        age_now;
      logic [23:0]        life_limit;
      logic               stuck_in;
      logic signed [31:0] rot_angle;
      logic signed [31:0] rot_rate;
      logic [15:0]        time_step;
   } pps_item_type;

   // fields that ride along unchanged (or settled early) down the pipe
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] angle;
      logic [23:0]        age;
      logic               active;
      logic               stuck;
      logic [15:0]        dt;
   } pps_carry_type;

   // hand-off from flight to ground section
   typedef struct packed {
      pps_carry_type      c;
      logic signed [31:0] vx_damp;
      logic signed [31:0] vy_damp;
      logic signed [31:0] px_move;
      logic signed [31:0] py_move;
      logic signed [31:0] vx_bnc;
      logic signed [31:0] vy_bnc;
   } pps_mid_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic [23:0]        new_age;
      logic               still_active;
      logic               stuck_out;
      logic signed [31:0] new_angle;
   } pps_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat32(34'(a) + 34'(b));
   endfunction

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
      return sat32(-(34'(a)));
   endfunction

   // Q16.16 times unsigned 16-bit factor, exact
   function automatic logic signed [48:0] mul_u16(input logic signed [31:0] a,
                                                  input logic [15:0] f);
      return 49'(a) * 49'($signed({1'b0, f}));
   endfunction

   // round half up, drop 16 fraction bits, saturate
   function automatic logic signed [31:0] rnd_q16(input logic signed [48:0] p);
      logic signed [48:0] b;
      logic signed [32:0] q;
      b = p + 49'sd32768;
      q = b[48:16];
      return sat32(34'(q));
   endfunction

   // round half up, drop 15 fraction bits, saturate
   function automatic logic signed [31:0] rnd_q15(input logic signed [48:0] p);
      logic signed [48:0] b;
      logic signed [33:0] q;
      b = p + 49'sd16384;
      q = b[48:15];
      return sat32(q);
   endfunction

   function automatic logic [63:0] square(input logic signed [31:0] a);
      logic signed [63:0] s;
      s = 64'(a) * 64'(a);
      return s;
   endfunction

endpackage

FILE: hdl/particle_physics_step_top.sv
// ----------------------------------------------------------------------------
// particle_physics_step_top
// One Euler step of a particle with gravity, damping and ground bounce.
//
//   channel   dir   handshake              payload
//   req       in    req_valid / req_stall  particle state + time step
//   rsp       out   rsp_valid / rsp_stall  updated particle state
//   csr       in    psel/penable/pwrite    eight config registers, 4-byte step
//
// Ten register stages from an accepted req word to the rsp word; one word
// enters per cycle when the output drains.
// The stage count is set by the dependent multiply chain: gravity, damping,
// motion/bounce and grip each take a product stage plus a rounding stage,
// then the vx square and the stick compare take one stage each.
// Reset clears the valid bits and loads the register defaults; no sweep.
// A stalled rsp freezes only the stages that are full: empty slots behind
// it keep filling, and req_stall rises only once every stage holds a word.
// ----------------------------------------------------------------------------
module particle_physics_step_top (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [31:0]              req_pos_x,
   input  logic signed [31:0]              req_pos_y,
   input  logic signed [31:0]              req_vel_x,
   input  logic signed [31:0]              req_vel_y,
   input  logic [23:0]                     req_age_now,
   input  logic [23:0]                     req_life_limit,
   input  logic                            req_stuck_in,
   input  logic signed [31:0]              req_rot_angle,
   input  logic signed [31:0]              req_rot_rate,
   input  logic [15:0]                     req_time_step,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [31:0]              rsp_new_pos_x,
   output logic signed [31:0]              rsp_new_pos_y,
   output logic signed [31:0]              rsp_new_vel_x,
   output logic signed [31:0]              rsp_new_vel_y,
   output logic [23:0]                     rsp_new_age,
   output logic                            rsp_still_active,
   output logic                            rsp_stuck_out,
   output logic signed [31:0]              rsp_new_angle,
   // config port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pps_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import pps_pkg::*;

   pps_cfg_type           cfg;
   pps_item_type          item;
   pps_mid_type           mid;
   pps_rsp_type           rsp;
   logic [PIPE_DEPTH-1:0] stage_en;

   // registers may only be rewritten while the pipe is empty (a rule for the user that
   // the block does not enforce), so every stage reads them directly
   pps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // one shared enable chain for all ten stages
   pps_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .stage_en  (stage_en)
   );

   always_comb begin
      item.pos_x      = req_pos_x;
      item.pos_y      = req_pos_y;
      item.vel_x      = req_vel_x;
      item.vel_y      = req_vel_y;
      item.age_now    = req_age_now;
      item.life_limit = req_life_limit;
      item.stuck_in   = req_stuck_in;
      item.rot_angle  = req_rot_angle;
      item.rot_rate   = req_rot_rate;
      item.time_step  = req_time_step;
   end

   // stages 0..5: age, gravity, spin, damping, motion, bounce
   pps_flight u_flight (
      .clock (clock),
      .en    (stage_en[FLIGHT_STAGES-1:0]),
      .cfg   (cfg),
      .item  (item),
      .mid   (mid)
   );

   // stages 6..9: contact, grip, stick test; stage 9 is the output register
   pps_ground u_ground (
      .clock (clock),
      .en    (stage_en[PIPE_DEPTH-1:FLIGHT_STAGES]),
      .cfg   (cfg),
      .mid   (mid),
      .rsp   (rsp)
   );

   assign rsp_new_pos_x    = rsp.new_pos_x;
   assign rsp_new_pos_y    = rsp.new_pos_y;
   assign rsp_new_vel_x    = rsp.new_vel_x;
   assign rsp_new_vel_y    = rsp.new_vel_y;
   assign rsp_new_age      = rsp.new_age;
   assign rsp_still_active = rsp.still_active;
   assign rsp_stuck_out    = rsp.stuck_out;
   assign rsp_new_angle    = rsp.new_angle;

endmodule

FILE: hdl/pps_csr.sv
// ----------------------------------------------------------------------------
// pps_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module pps_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pps_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output pps_pkg::pps_cfg_type            cfg
);
   import pps_pkg::*;

   pps_cfg_type cfg_ff, cfg_in;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_GRAVITY_X:      cfg_in.gravity_x      = pwdata;
            REG_GRAVITY_Y:      cfg_in.gravity_y      = pwdata;
            REG_DAMPING:        cfg_in.damping        = pwdata[15:0];
            REG_BOUNCE:         cfg_in.bounce         = pwdata[15:0];
            REG_SURFACE_GRIP:   cfg_in.surface_grip   = pwdata[15:0];
            REG_COLLIDE_ENABLE: cfg_in.collide_enable = pwdata[0];
            REG_STICK_ENABLE:   cfg_in.stick_enable   = pwdata[0];
            REG_CONTACT_OFFSET: cfg_in.contact_offset = pwdata[30:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity_x      <= RST_GRAVITY_X;
         cfg_ff.gravity_y      <= RST_GRAVITY_Y;
         cfg_ff.damping        <= RST_DAMPING;
         cfg_ff.bounce         <= RST_BOUNCE;
         cfg_ff.surface_grip   <= RST_SURFACE_GRIP;
         cfg_ff.collide_enable <= RST_COLLIDE_ENABLE;
         cfg_ff.stick_enable   <= RST_STICK_ENABLE;
         cfg_ff.contact_offset <= RST_CONTACT_OFFSET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GRAVITY_X:      prdata = cfg_ff.gravity_x;
         REG_GRAVITY_Y:      prdata = cfg_ff.gravity_y;
         REG_DAMPING:        prdata = 32'(cfg_ff.damping);
         REG_BOUNCE:         prdata = 32'(cfg_ff.bounce);
         REG_SURFACE_GRIP:   prdata = 32'(cfg_ff.surface_grip);
         REG_COLLIDE_ENABLE: prdata = 32'(cfg_ff.collide_enable);
         REG_STICK_ENABLE:   prdata = 32'(cfg_ff.stick_enable);
         REG_CONTACT_OFFSET: prdata = 32'(cfg_ff.contact_offset);
         default:            prdata = '0;
      endcase
   end

endmodule

FILE: hdl/pps_pipe_ctl.sv
// ----------------------------------------------------------------------------
// pps_pipe_ctl
// Valid bits and per-stage load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
`include "particle_physics_step_top_defines.svh"

module pps_pipe_ctl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_stall,
   output logic                             out_valid,
   input  logic                             out_stall,
   output logic [pps_pkg::PIPE_DEPTH-1:0]   stage_en
);
   import pps_pkg::*;

   logic [PIPE_DEPTH-1:0] v_ff, v_in;
   logic                  in_acc, out_acc;

   // a stage loads when empty or when the one after it moves on
   always_comb begin
      stage_en[PIPE_DEPTH-1] = !v_ff[PIPE_DEPTH-1] || !out_stall;
      for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
         stage_en[i] = !v_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (stage_en[0]) begin
         v_in[0] = in_valid;
      end
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         if (stage_en[i]) begin
            v_in[i] = v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_stall  = !stage_en[0];
   assign out_valid = v_ff[PIPE_DEPTH-1];
   assign in_acc    = in_valid && !in_stall;
   assign out_acc   = out_valid && !out_stall;

   // input only backs up once every stage holds a word
   `PPS_ASSERT_IMPL(a_stall_only_full, clock, reset, in_stall, &v_ff, "input stalled with a bubble in the pipe")
   // a word leaving the tail frees room at the head in the same cycle
   `PPS_ASSERT_IMPL(a_drain_opens_head, clock, reset, out_acc, !in_stall, "tail moved but head stalled")
   // words in flight track accepts minus deliveries
   `PPS_ASSERT_IMPL(a_count_kept, clock, reset, !$past(reset), $countones(v_ff) == $past($countones(v_ff)) + $past(in_acc) - $past(out_acc), "word count lost or duplicated")

endmodule

FILE: hdl/pps_flight.sv
// ----------------------------------------------------------------------------
// pps_flight
// Age, gravity, damping, motion and bounce products (six stages).
// ----------------------------------------------------------------------------
module pps_flight (
   input  logic                                 clock,
   input  logic [pps_pkg::FLIGHT_STAGES-1:0]    en,
   input  pps_pkg::pps_cfg_type                 cfg,
   input  pps_pkg::pps_item_type                item,
   output pps_pkg::pps_mid_type                 mid
);
   import pps_pkg::*;

   typedef struct packed {
      pps_carry_type      c;
      logic signed [48:0] p_gx;
      logic signed [48:0] p_gy;
      logic signed [48:0] p_ang;
   } s0_type;

   typedef struct packed {
      pps_carry_type      c;
      logic signed [31:0] vx1;
      logic signed [31:0] vy1;
   } s1_type;

   typedef struct packed {
      pps_carry_type      c;
      logic signed [48:0] p_dx;
      logic signed [48:0] p_dy;
   } s2_type;

   typedef struct packed {
      pps_carry_type      c;
      logic signed [31:0] vx2;
      logic signed [31:0] vy2;
   } s3_type;

   typedef struct packed {
      pps_carry_type      c;
      logic signed [31:0] vx2;
      logic signed [31:0] vy2;
      logic signed [48:0] p_px;
      logic signed [48:0] p_py;
      logic signed [48:0] p_bx;
      logic signed [48:0] p_by;
   } s4_type;

   s0_type      s0_ff, s0_in;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   s4_type      s4_ff, s4_in;
   pps_mid_type s5_ff, s5_in;
   logic [24:0] age_sum;
   logic [23:0] age_sat;

   // stage 0: advance age, gravity and spin products
   always_comb begin
      age_sum = {1'b0, item.age_now} + 25'(item.time_step);
      age_sat = age_sum[24] ? AGE_MAX : age_sum[23:0];
      s0_in.c.pos_x  = item.pos_x;
      s0_in.c.pos_y  = item.pos_y;
      s0_in.c.vel_x  = item.vel_x;
      s0_in.c.vel_y  = item.vel_y;
      s0_in.c.angle  = item.rot_angle;
      s0_in.c.age    = age_sat;
      s0_in.c.active = age_sat < item.life_limit;
      s0_in.c.stuck  = item.stuck_in;
      s0_in.c.dt     = item.time_step;
      s0_in.p_gx     = mul_u16(cfg.gravity_x, item.time_step);
      s0_in.p_gy     = mul_u16(cfg.gravity_y, item.time_step);
      s0_in.p_ang    = mul_u16(item.rot_rate, item.time_step);
   end

   // stage 1: velocity += g*dt; angle settles here
   always_comb begin
      s1_in.c   = s0_ff.c;
      s1_in.vx1 = add_sat(s0_ff.c.vel_x, rnd_q16(s0_ff.p_gx));
      s1_in.vy1 = add_sat(s0_ff.c.vel_y, rnd_q16(s0_ff.p_gy));
      if (s0_ff.c.active) begin
         s1_in.c.angle = add_sat(s0_ff.c.angle, rnd_q16(s0_ff.p_ang));
      end
   end

   // stage 2: damping products
   always_comb begin
      s2_in.c    = s1_ff.c;
      s2_in.p_dx = mul_u16(s1_ff.vx1, cfg.damping);
      s2_in.p_dy = mul_u16(s1_ff.vy1, cfg.damping);
   end

   // stage 3: damped velocity
   always_comb begin
      s3_in.c   = s2_ff.c;
      s3_in.vx2 = rnd_q15(s2_ff.p_dx);
      s3_in.vy2 = rnd_q15(s2_ff.p_dy);
   end

   // stage 4: motion and bounce products side by side
   always_comb begin
      s4_in.c    = s3_ff.c;
      s4_in.vx2  = s3_ff.vx2;
      s4_in.vy2  = s3_ff.vy2;
      s4_in.p_px = mul_u16(s3_ff.vx2, s3_ff.c.dt);
      s4_in.p_py = mul_u16(s3_ff.vy2, s3_ff.c.dt);
      s4_in.p_bx = mul_u16(s3_ff.vx2, cfg.bounce);
      s4_in.p_by = mul_u16(neg_sat(s3_ff.vy2), cfg.bounce);
   end

   // stage 5: moved position, bounced velocity
   always_comb begin
      s5_in.c       = s4_ff.c;
      s5_in.vx_damp = s4_ff.vx2;
      s5_in.vy_damp = s4_ff.vy2;
      s5_in.px_move = add_sat(s4_ff.c.pos_x, rnd_q16(s4_ff.p_px));
      s5_in.py_move = add_sat(s4_ff.c.pos_y, rnd_q16(s4_ff.p_py));
      s5_in.vx_bnc  = rnd_q15(s4_ff.p_bx);
      s5_in.vy_bnc  = rnd_q15(s4_ff.p_by);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_ff <= s0_in;
      end
      if (en[1]) begin
         s1_ff <= s1_in;
      end
      if (en[2]) begin
         s2_ff <= s2_in;
      end
      if (en[3]) begin
         s3_ff <= s3_in;
      end
      if (en[4]) begin
         s4_ff <= s4_in;
      end
      if (en[5]) begin
         s5_ff <= s5_in;
      end
   end

   assign mid = s5_ff;

endmodule

FILE: hdl/pps_ground.sv
// ----------------------------------------------------------------------------
// pps_ground
// Ground contact, grip, stick test and final select (four stages).
// ----------------------------------------------------------------------------
module pps_ground (
   input  logic                                 clock,
   input  logic [pps_pkg::GROUND_STAGES-1:0]    en,
   input  pps_pkg::pps_cfg_type                 cfg,
   input  pps_pkg::pps_mid_type                 mid,
   output pps_pkg::pps_rsp_type                 rsp
);
   import pps_pkg::*;

   typedef struct packed {
      pps_carry_type      c;
      logic signed [31:0] vx_damp;
      logic signed [31:0] vy_damp;
      logic signed [31:0] px_move;
      logic signed [31:0] py_move;
      logic signed [31:0] vy_bnc;
      logic               collide;
   } base_type;

   typedef struct packed {
      base_type           b;
      logic signed [48:0] p_grip;
      logic [63:0]        sq_y;
   } s6_type;

   typedef struct packed {
      base_type           b;
      logic signed [31:0] vx_grip;
      logic [63:0]        sq_y;
   } s7_type;

   typedef struct packed {
      base_type           b;
      logic signed [31:0] vx_grip;
      logic [63:0]        sq_y;
      logic [63:0]        sq_x;
   } s8_type;

   s6_type      s6_ff, s6_in;
   s7_type      s7_ff, s7_in;
   s8_type      s8_ff, s8_in;
   pps_rsp_type s9_ff, s9_in;
   logic        slow;
   logic        free_fall;

   // stage 6: contact test, grip product, vy squared
   always_comb begin
      s6_in.b.c       = mid.c;
      s6_in.b.vx_damp = mid.vx_damp;
      s6_in.b.vy_damp = mid.vy_damp;
      s6_in.b.px_move = mid.px_move;
      s6_in.b.py_move = mid.py_move;
      s6_in.b.vy_bnc  = mid.vy_bnc;
      s6_in.b.collide = cfg.collide_enable && (mid.py_move <= GROUND_Y);
      s6_in.p_grip    = mul_u16(mid.vx_bnc, cfg.surface_grip);
      s6_in.sq_y      = square(mid.vy_bnc);
   end

   // stage 7: gripped vx
   always_comb begin
      s7_in.b       = s6_ff.b;
      s7_in.vx_grip = rnd_q15(s6_ff.p_grip);
      s7_in.sq_y    = s6_ff.sq_y;
   end

   // stage 8: vx squared
   always_comb begin
      s8_in.b       = s7_ff.b;
      s8_in.vx_grip = s7_ff.vx_grip;
      s8_in.sq_y    = s7_ff.sq_y;
      s8_in.sq_x    = square(s7_ff.vx_grip);
   end

   // stage 9: stick test and result select
   always_comb begin
      slow      = cfg.stick_enable &&
                  ((65'(s8_ff.sq_x) + 65'(s8_ff.sq_y)) < STICK_LIMIT);
      free_fall = s8_ff.b.c.active && !s8_ff.b.c.stuck;

      s9_in.new_age      = s8_ff.b.c.age;
      s9_in.still_active = s8_ff.b.c.active;
      s9_in.new_angle    = s8_ff.b.c.angle;
      s9_in.new_pos_x    = s8_ff.b.c.pos_x;
      s9_in.new_pos_y    = s8_ff.b.c.pos_y;
      s9_in.new_vel_x    = s8_ff.b.c.vel_x;
      s9_in.new_vel_y    = s8_ff.b.c.vel_y;
      s9_in.stuck_out    = s8_ff.b.c.stuck;

      if (free_fall) begin
         s9_in.new_pos_x = s8_ff.b.px_move;
         if (s8_ff.b.collide) begin
            s9_in.new_pos_y = add_sat(GROUND_Y, 32'(cfg.contact_offset));
            s9_in.new_vel_x = slow ? '0 : s8_ff.vx_grip;
            s9_in.new_vel_y = slow ? '0 : s8_ff.b.vy_bnc;
            s9_in.stuck_out = slow;
         end else begin
            s9_in.new_pos_y = s8_ff.b.py_move;
            s9_in.new_vel_x = s8_ff.b.vx_damp;
            s9_in.new_vel_y = s8_ff.b.vy_damp;
            s9_in.stuck_out = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s6_ff <= s6_in;
      end
      if (en[1]) begin
         s7_ff <= s7_in;
      end
      if (en[2]) begin
         s8_ff <= s8_in;
      end
      if (en[3]) begin
         s9_ff <= s9_in;
      end
   end

   assign rsp = s9_ff;

endmodule

FILE: verif/particle_step_monitor.sv
// ----------------------------------------------------------------------------
// particle_step_monitor
// Watches the req, rsp and csr ports of the particle step block. It keeps a
// copy of the registers, predicts each rsp word from each accepted req word,
// and compares the two field by field, oldest first.
// ----------------------------------------------------------------------------
module particle_step_monitor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic signed [31:0]              req_pos_x,
   input  logic signed [31:0]              req_pos_y,
   input  logic signed [31:0]              req_vel_x,
   input  logic signed [31:0]              req_vel_y,
   input  logic [23:0]                     req_age_now,
   input  logic [23:0]                     req_life_limit,
   input  logic                            req_stuck_in,
   input  logic signed [31:0]              req_rot_angle,
   input  logic signed [31:0]              req_rot_rate,
   input  logic [15:0]                     req_time_step,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic signed [31:0]              rsp_new_pos_x,
   input  logic signed [31:0]              rsp_new_pos_y,
   input  logic signed [31:0]              rsp_new_vel_x,
   input  logic signed [31:0]              rsp_new_vel_y,
   input  logic [23:0]                     rsp_new_age,
   input  logic                            rsp_still_active,
   input  logic                            rsp_stuck_out,
   input  logic signed [31:0]              rsp_new_angle,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pps_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   input  logic                            csr_pready,
   output int                              mismatch_count,
   output int                              words_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;
   import pps_pkg::*;

   pps_cfg_type settings;
   pps_rsp_type expected_steps[$];
   int          result_count;

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // exact product, round half up by adding half an LSB then flooring
   function automatic longint scale_round(input longint a, input longint b, input int frac);
      longint p;
      p = a * b + (64'sd1 <<< (frac - 1));
      return clamp32(p >>> frac);
   endfunction

   function automatic pps_rsp_type advance_particle(input pps_item_type p,
                                                    input pps_cfg_type c);
      longint      px, py, vx, vy, ang, rate, dt;
      logic [24:0] age;
      logic        active, stuck;
      logic [63:0] ax, ay;
      logic [64:0] mag;
      pps_rsp_type r;
      px    = longint'($signed(p.pos_x));
      py    = longint'($signed(p.pos_y));
      vx    = longint'($signed(p.vel_x));
      vy    = longint'($signed(p.vel_y));
      ang   = longint'($signed(p.rot_angle));
      rate  = longint'($signed(p.rot_rate));
      dt    = longint'(p.time_step);
      stuck = p.stuck_in;
      age   = 25'(p.age_now) + 25'(p.time_step);
      if (age > 25'h0FF_FFFF) age = 25'h0FF_FFFF;
      active = (age[23:0] < p.life_limit);
      if (active) begin
         if (!stuck) begin
            vx = clamp32(vx + scale_round(longint'($signed(c.gravity_x)), dt, 16));
            vy = clamp32(vy + scale_round(longint'($signed(c.gravity_y)), dt, 16));
            vx = scale_round(vx, longint'(c.damping), 15);
            vy = scale_round(vy, longint'(c.damping), 15);
            px = clamp32(px + scale_round(vx, dt, 16));
            py = clamp32(py + scale_round(vy, dt, 16));
            if (c.collide_enable && py <= longint'($signed(GROUND_Y))) begin
               vy = clamp32(-vy);
               vx = scale_round(vx, longint'(c.bounce), 15);
               vy = scale_round(vy, longint'(c.bounce), 15);
               vx = scale_round(vx, longint'(c.surface_grip), 15);
               if (c.stick_enable) begin
                  ax  = (vx < 0) ? -vx : vx;
                  ay  = (vy < 0) ? -vy : vy;
                  mag = ax * ax + ay * ay;
                  if (mag < STICK_LIMIT) begin
                     stuck = 1'b1;
                     vx    = 0;
                     vy    = 0;
                  end
               end
               py = clamp32(longint'($signed(GROUND_Y)) + longint'(c.contact_offset));
            end
         end
         ang = clamp32(ang + scale_round(rate, dt, 16));
      end
      r.new_pos_x    = px[31:0];
      r.new_pos_y    = py[31:0];
      r.new_vel_x    = vx[31:0];
      r.new_vel_y    = vy[31:0];
      r.new_age      = age[23:0];
      r.still_active = active;
      r.stuck_out    = stuck;
      r.new_angle    = ang[31:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns rsp word %0d %s: got %h, expected %h", $time, result_count, what,
               got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      pps_item_type item;
      pps_rsp_type  seen;
      pps_rsp_type  want;
      if (reset) begin
         settings = '{gravity_x: RST_GRAVITY_X, gravity_y: RST_GRAVITY_Y,
                      damping: RST_DAMPING, bounce: RST_BOUNCE,
                      surface_grip: RST_SURFACE_GRIP, collide_enable: RST_COLLIDE_ENABLE,
                      stick_enable: RST_STICK_ENABLE, contact_offset: RST_CONTACT_OFFSET};
         expected_steps.delete();
         words_in_flight = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_GRAVITY_X:      settings.gravity_x      = csr_pwdata;
               REG_GRAVITY_Y:      settings.gravity_y      = csr_pwdata;
               REG_DAMPING:        settings.damping        = csr_pwdata[15:0];
               REG_BOUNCE:         settings.bounce         = csr_pwdata[15:0];
               REG_SURFACE_GRIP:   settings.surface_grip   = csr_pwdata[15:0];
               REG_COLLIDE_ENABLE: settings.collide_enable = csr_pwdata[0];
               REG_STICK_ENABLE:   settings.stick_enable   = csr_pwdata[0];
               REG_CONTACT_OFFSET: settings.contact_offset = csr_pwdata[30:0];
               default: ;
            endcase
         end
         // check before queueing: a word cannot come out in the cycle it goes in
         if (rsp_valid && !rsp_stall) begin
            seen = '{new_pos_x: rsp_new_pos_x, new_pos_y: rsp_new_pos_y,
                     new_vel_x: rsp_new_vel_x, new_vel_y: rsp_new_vel_y,
                     new_age: rsp_new_age, still_active: rsp_still_active,
                     stuck_out: rsp_stuck_out, new_angle: rsp_new_angle};
            if (expected_steps.size() == 0) begin
               report_mismatch("arrived with nothing pending, new_pos_x", seen.new_pos_x, 0);
            end else begin
               want = expected_steps.pop_front();
               if (seen.new_pos_x !== want.new_pos_x)
                  report_mismatch("new_pos_x", seen.new_pos_x, want.new_pos_x);
               if (seen.new_pos_y !== want.new_pos_y)
                  report_mismatch("new_pos_y", seen.new_pos_y, want.new_pos_y);
               if (seen.new_vel_x !== want.new_vel_x)
                  report_mismatch("new_vel_x", seen.new_vel_x, want.new_vel_x);
               if (seen.new_vel_y !== want.new_vel_y)
                  report_mismatch("new_vel_y", seen.new_vel_y, want.new_vel_y);
               if (seen.new_age !== want.new_age)
                  report_mismatch("new_age", 32'(seen.new_age), 32'(want.new_age));
               if (seen.still_active !== want.still_active)
                  report_mismatch("still_active", 32'(seen.still_active),
                                  32'(want.still_active));
               if (seen.stuck_out !== want.stuck_out)
                  report_mismatch("stuck_out", 32'(seen.stuck_out), 32'(want.stuck_out));
               if (seen.new_angle !== want.new_angle)
                  report_mismatch("new_angle", seen.new_angle, want.new_angle);
            end
            result_count++;
         end
         if (req_valid && !req_stall) begin
            item = '{pos_x: req_pos_x, pos_y: req_pos_y, vel_x: req_vel_x,
                     vel_y: req_vel_y, age_now: req_age_now, life_limit: req_life_limit,
                     stuck_in: req_stuck_in, rot_angle: req_rot_angle,
                     rot_rate: req_rot_rate, time_step: req_time_step};
            expected_steps.insert(expected_steps.size(), advance_particle(item, settings));
         end
         words_in_flight = expected_steps.size();
      end
   end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives particle records into the particle step block and directed, then random,
// register settings between phases, with random gaps on req and random stalls on rsp.
// The monitor beside the block predicts and checks every rsp word.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pps_pkg::*;

   // cycles with no handshake of any kind before the run is declared hung;
   // the slowest legal stretch is the longest req gap, the longest rsp stall and the pipe
   localparam int QUIET_LIMIT = 2000;
   localparam int ONE         = 65536;          // 1.0 in Q16.16
   localparam int RANDOM_RUNS = 8;              // register settings in the random part
   localparam int RUN_WORDS   = 185;            // req words per setting

   typedef enum {STYLE_MIXED, STYLE_LOW, STYLE_HIGH} draw_style_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic signed [31:0]    req_pos_x;
   logic signed [31:0]    req_pos_y;
   logic signed [31:0]    req_vel_x;
   logic signed [31:0]    req_vel_y;
   logic [23:0]           req_age_now;
   logic [23:0]           req_life_limit;
   logic                  req_stuck_in;
   logic signed [31:0]    req_rot_angle;
   logic signed [31:0]    req_rot_rate;
   logic [15:0]           req_time_step;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [31:0]    rsp_new_pos_x;
   logic signed [31:0]    rsp_new_pos_y;
   logic signed [31:0]    rsp_new_vel_x;
   logic signed [31:0]    rsp_new_vel_y;
   logic [23:0]           rsp_new_age;
   logic                  rsp_still_active;
   logic                  rsp_stuck_out;
   logic signed [31:0]    rsp_new_angle;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int words_in_flight;
   bit burst_mode;      // when set, neither side idles

   particle_physics_step_top dut (.*);

   particle_step_monitor step_monitor (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- helpers

   function automatic pps_item_type particle(input logic [31:0] px, py, vx, vy,
                                             input logic [23:0] age, life,
                                             input logic stuck,
                                             input logic [31:0] ang, rate,
                                             input logic [15:0] dt);
      return '{pos_x: px, pos_y: py, vel_x: vx, vel_y: vy, age_now: age,
               life_limit: life, stuck_in: stuck, rot_angle: ang,
               rot_rate: rate, time_step: dt};
   endfunction

   // low extreme, high extreme or a typical value, per register
   function automatic logic [31:0] pick32(input draw_style_type style,
                                          input logic [31:0] lo, hi, typical);
      int roll;
      roll = $urandom_range(0, 7);
      case (style)
         STYLE_LOW:  return lo;
         STYLE_HIGH: return hi;
         default:    return (roll == 0) ? lo : (roll == 1) ? hi : typical;
      endcase
   endfunction

   function automatic pps_cfg_type draw_settings(input draw_style_type style);
      pps_cfg_type s;
      s.gravity_x      = pick32(style, 32'h8000_0000, 32'h7FFF_FFFF,
                                int'($urandom_range(0, 13107200)) - 6553600);
      s.gravity_y      = pick32(style, 32'h8000_0000, 32'h7FFF_FFFF,
                                -int'($urandom_range(0, 32768000)));
      s.damping        = 16'(pick32(style, 0, 16'hFFFF, $urandom_range(26000, 32768)));
      s.bounce         = 16'(pick32(style, 0, 16'hFFFF, $urandom_range(0, 32768)));
      s.surface_grip   = 16'(pick32(style, 0, 16'hFFFF, $urandom_range(16000, 32768)));
      s.collide_enable = 1'(pick32(style, 0, 1, $urandom_range(0, 3) != 0));
      s.stick_enable   = 1'(pick32(style, 0, 1, $urandom_range(0, 1)));
      s.contact_offset = 31'(pick32(style, 0, 31'h7FFF_FFFF, $urandom_range(0, 655360)));
      return s;
   endfunction

   // Most records are live particles near the ground so that the bounce and
   // stick paths see real traffic; the rest are ones at a random height, expiring ones and raw noise.
   function automatic pps_item_type draw_particle();
      pps_item_type p;
      int kind;
      kind = $urandom_range(0, 99);
      p.pos_x      = int'($urandom_range(0, 131072000)) - 65536000;
      p.pos_y      = GROUND_Y + int'($urandom_range(0, 2621440)) - 1310720;
      p.vel_x      = int'($urandom_range(0, 6553600)) - 3276800;
      p.vel_y      = int'($urandom_range(0, 6553600)) - 3276800;
      p.age_now    = 24'($urandom_range(0, 10 * ONE));
      p.time_step  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 4369));
      p.life_limit = 24'(int'(p.age_now) + int'(p.time_step) +
                         int'($urandom_range(1, 10 * ONE)));
      p.stuck_in   = ($urandom_range(0, 9) == 0);
      p.rot_angle  = int'($urandom_range(0, 47185920)) - 23592960;
      p.rot_rate   = int'($urandom_range(0, 94371840)) - 47185920;
      if (kind < 55) begin
         // flight near the ground, as drawn above
      end else if (kind < 70) begin
         // slow particles settling, the ones that can stick
         p.vel_x     = int'($urandom_range(0, 1572864)) - 786432;
         p.vel_y     = int'($urandom_range(0, 1572864)) - 786432;
         p.time_step = 16'($urandom_range(0, 1092));
         p.stuck_in  = 1'b0;
      end else if (kind < 78) begin
         p.pos_y = int'($urandom_range(0, 131072000)) - 65536000;
      end else if (kind < 86) begin
         p.life_limit = 24'($urandom_range(0, int'(p.age_now) + int'(p.time_step)));
      end else begin
         p.pos_x      = $urandom;
         p.pos_y      = $urandom;
         p.vel_x      = $urandom;
         p.vel_y      = $urandom;
         p.age_now    = 24'($urandom);
         p.life_limit = 24'($urandom);
         p.stuck_in   = 1'($urandom);
         p.rot_angle  = $urandom;
         p.rot_rate   = $urandom;
         p.time_step  = 16'($urandom);
      end
      return p;
   endfunction

   // Called at a falling edge, returns at a falling edge. valid stays high
   // across back-to-back words, so it only gets one assignment per step.
   task automatic send_particle(input pps_item_type p);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_pos_x      <= p.pos_x;
      req_pos_y      <= p.pos_y;
      req_vel_x      <= p.vel_x;
      req_vel_y      <= p.vel_y;
      req_age_now    <= p.age_now;
      req_life_limit <= p.life_limit;
      req_stuck_in   <= p.stuck_in;
      req_rot_angle  <= p.rot_angle;
      req_rot_rate   <= p.rot_rate;
      req_time_step  <= p.time_step;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // setup then access; psel stays up between back-to-back writes
   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   task automatic write_settings(input pps_cfg_type s);
      write_register(REG_GRAVITY_X, s.gravity_x);
      write_register(REG_GRAVITY_Y, s.gravity_y);
      write_register(REG_DAMPING, {16'h0, s.damping});
      write_register(REG_BOUNCE, {16'h0, s.bounce});
      write_register(REG_SURFACE_GRIP, {16'h0, s.surface_grip});
      write_register(REG_COLLIDE_ENABLE, {31'h0, s.collide_enable});
      write_register(REG_STICK_ENABLE, {31'h0, s.stick_enable});
      write_register(REG_CONTACT_OFFSET, {1'b0, s.contact_offset});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // every req word gives exactly one rsp word, so an empty monitor queue
   // means the pipe is empty and registers may change
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (words_in_flight != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      pps_cfg_type s;
      reset          = 1'b1;
      burst_mode     = 1'b0;
      req_valid      = 1'b0;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_vel_x      = '0;
      req_vel_y      = '0;
      req_age_now    = '0;
      req_life_limit = '0;
      req_stuck_in   = 1'b0;
      req_rot_angle  = '0;
      req_rot_rate   = '0;
      req_time_step  = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings.
      // zero lifetime always expires
      send_particle(particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // age saturates at the top of its range, then expires
      send_particle(particle(10 * ONE, 20 * ONE, ONE, -ONE, 24'hFF_FFFF, 24'hFF_FFFF, 0,
                             45 * ONE, ONE, 16'hFFFF));
      // expired and stuck: everything passes through, even below ground
      send_particle(particle(3 * ONE, -250 * ONE, 7 * ONE, -9 * ONE, 100, 50, 1,
                             30 * ONE, ONE, 1000));
      // age lands exactly on the lifetime, then one short of it
      send_particle(particle(ONE, 50 * ONE, 2 * ONE, 0, 100, 150, 0, 0, 0, 50));
      send_particle(particle(ONE, 50 * ONE, 2 * ONE, 0, 100, 151, 0, 0, 0, 50));
      // stuck particle: no physics, angle still turns
      send_particle(particle(5 * ONE, -199 * ONE, 3 * ONE, -3 * ONE, 0, 10 * ONE, 1,
                             90 * ONE, 180 * ONE, 16'h8000));
      // plain flight at about 60 steps per second
      send_particle(particle(0, 100 * ONE, 5 * ONE, 3 * ONE, 0, 10 * ONE, 0, 0,
                             30 * ONE, 1092));
      // falls through the ground and bounces
      send_particle(particle(2 * ONE, -199 * ONE, 4 * ONE, -50 * ONE, ONE, 10 * ONE, 0,
                             0, 0, 3277));
      // zero time step
      send_particle(particle(7 * ONE, 10 * ONE, ONE, ONE, ONE, 2 * ONE, 0, 5 * ONE,
                             100 * ONE, 0));
      // everything at the positive and negative rails
      send_particle(particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             0, 24'hFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
      send_particle(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             0, 24'hFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 16'hFFFF));
      // rounding ties of +/- half an LSB go up
      send_particle(particle(0, 0, 0, 0, 0, ONE, 0, 0, 1, 16'h8000));
      send_particle(particle(0, 0, 0, 0, 0, ONE, 0, 0, -1, 16'h8000));
      wait_drained();

      // Unity factors, no gravity, sticking on, no push-out: ground contacts
      // that keep the speed as given unless they stick.
      s = '{gravity_x: 0, gravity_y: 0, damping: 16'd32768, bounce: 16'd32768,
            surface_grip: 16'd32768, collide_enable: 1'b1, stick_enable: 1'b1,
            contact_offset: 31'd0};
      write_settings(s);
      // reflecting the most negative vy saturates to the top
      send_particle(particle(0, GROUND_Y, 0, 32'h8000_0000, 0, ONE, 0, 0, 0, 0));
      send_particle(particle(0, GROUND_Y, ONE, -ONE, 0, ONE, 0, 0, 0, 0));
      // speed squared exactly at the stick limit, then just under it
      send_particle(particle(0, GROUND_Y, 10 * ONE, 0, 0, ONE, 0, 0, 0, 0));
      send_particle(particle(0, GROUND_Y, 10 * ONE - 1, 0, 0, ONE, 0, 0, 0, 0));
      // one LSB above the ground: no contact
      send_particle(particle(0, GROUND_Y + 1, ONE, 0, 0, ONE, 0, 0, 0, 0));
      wait_drained();

      // factors above one and the largest push-out
      s = '{gravity_x: 32'h7FFF_FFFF, gravity_y: 32'h8000_0000, damping: 16'hFFFF,
            bounce: 16'hFFFF, surface_grip: 16'hFFFF, collide_enable: 1'b1,
            stick_enable: 1'b0, contact_offset: 31'h7FFF_FFFF};
      write_settings(s);
      send_particle(particle(0, GROUND_Y, 32'h7000_0000, -1000 * ONE, 0, ONE, 0, 0, 0,
                             16'h0100));
      send_particle(particle(0, 0, 32'h4000_0000, 32'hC000_0000, 0, ONE, 0, 0, 0,
                             16'hFFFF));
      wait_drained();

      // Random part: one setting per run, the first two at the extremes.
      // Burst mode, with no idling on either side, is drawn afresh every 40 words.
      for (int run = 0; run < RANDOM_RUNS; run++) begin
         write_settings(draw_settings((run == 0) ? STYLE_LOW :
                                      (run == 1) ? STYLE_HIGH : STYLE_MIXED));
         for (int n = 0; n < RUN_WORDS; n++) begin
            if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            send_particle(draw_particle());
         end
         wait_drained();
      end
      burst_mode = 1'b0;

      // wait past the pipe depth in case a stray word is still on its way
      repeat (PIPE_DEPTH + 4) @(negedge clock);
      if (mismatch_count == 0 && words_in_flight == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------- rsp side

   // Before each word the receiver holds stall for a random count, then
   // lowers it and waits for the word.
   initial begin : receiver
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = burst_mode ? 0 : $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pps_pkg.sv
hdl/pps_csr.sv
hdl/pps_pipe_ctl.sv
hdl/pps_flight.sv
hdl/pps_ground.sv
hdl/particle_physics_step_top.sv
verif/particle_step_monitor.sv
verif/testbench.sv
